>>> design/fcfs_pkg.sv
// Shared constants and payload types for the FCFS scheduling table.
package fcfs_pkg;

    // Capacity of the record table
    localparam int MAX_PROCS = 64;
    localparam int ADDR_W    = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    // Field widths
    localparam int ID_W   = 16;
    localparam int T_W    = 16;
    localparam int TIME_W = 23;
    localparam int WAIT_W = 22;

    // One stored process record
    typedef struct packed {
        logic [ID_W-1:0] proc_id;
        logic [T_W-1:0]  arrival;
        logic [T_W-1:0]  burst;
    } entry_t;

    // Input transaction payload
    typedef struct packed {
        logic [ID_W-1:0] proc_id;
        logic [T_W-1:0]  arrival_time;
        logic [T_W-1:0]  burst_time;
        logic            last_item;
    } rec_t;

    // Output transaction payload
    typedef struct packed {
        logic [ID_W-1:0]   out_proc_id;
        logic [T_W-1:0]    out_arrival;
        logic [T_W-1:0]    out_burst;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [WAIT_W-1:0] waiting_time;
        logic              overflow;
        logic              last_result;
    } res_t;

endpackage

>>> design/fcfs_rec_if.sv
// Valid/ready channel carrying process records into the block.
interface fcfs_rec_if;
    logic           valid;
    logic           ready;
    fcfs_pkg::rec_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/fcfs_res_if.sv
// Valid/ready channel carrying schedule results out of the block.
interface fcfs_res_if;
    logic           valid;
    logic           ready;
    fcfs_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/fcfs_schedule_metrics.sv
// FCFS scheduling table: insertion-sorted record store plus timeline sequencer.
//
// Records are kept in arrival order as they load: each accepted record is
// placed by an insertion step that reads one stored entry per cycle, and
// moves it up one slot while its arrival time is strictly later than the new
// one, so equal arrivals keep their load order. The insertion step is paced by
// the single read port of the record memory and the one shared arrival
// comparator, and the port is not ready while a record is being placed.
// Records beyond MAX_PROCS are dropped and flag every result of the set. On
// the record marked last the block walks the table and produces one result
// per stored record: it reads the entry, takes the start time, computes the
// completion, waiting and turnaround times, and holds each result until the
// sink takes it; the next set may be loaded once the final result is taken.
module fcfs_schedule_metrics (
    input  logic           clk,
    input  logic           rst_n,
    fcfs_rec_if.sink       records,
    fcfs_res_if.source     results
);

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SHIFT    = 3'd1;
    localparam logic [2:0] S_INSERT   = 3'd2;
    localparam logic [2:0] S_RUN_RD   = 3'd3;
    localparam logic [2:0] S_RUN_MAX  = 3'd4;
    localparam logic [2:0] S_RUN_ADD  = 3'd5;
    localparam logic [2:0] S_RUN_TURN = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;

    // Record memory
    fcfs_pkg::entry_t mem [fcfs_pkg::MAX_PROCS];

    // Control registers
    logic [2:0]                    state_reg, state_next;
    logic [fcfs_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                          dropped_reg, dropped_next;
    logic [fcfs_pkg::TIME_W-1:0]   clock_reg, clock_next;
    logic [fcfs_pkg::ADDR_W-1:0]   pos_reg, pos_next;
    logic                          last_reg, last_next;

    // Payload registers
    fcfs_pkg::entry_t              new_reg, new_next;
    fcfs_pkg::entry_t              rd_data_reg;
    logic [fcfs_pkg::TIME_W-1:0]   start_reg, start_next;
    fcfs_pkg::res_t                out_reg, out_next;

    // Memory access
    logic                          wr_en;
    logic [fcfs_pkg::ADDR_W-1:0]   wr_addr;
    fcfs_pkg::entry_t              wr_data;
    logic [fcfs_pkg::ADDR_W-1:0]   rd_addr;

    logic                          rec_accept;
    logic [fcfs_pkg::TIME_W-1:0]   rd_arr_ext;
    logic [fcfs_pkg::TIME_W-1:0]   rd_bur_ext;
    logic [fcfs_pkg::TIME_W-1:0]   done_time;
    logic [fcfs_pkg::TIME_W-1:0]   wait_full;

    assign records.ready = (state_reg == S_IDLE);
    assign results.valid = (state_reg == S_OUT);
    assign results.data  = out_reg;
    assign rec_accept    = records.valid && records.ready;

    assign rd_arr_ext = fcfs_pkg::TIME_W'(rd_data_reg.arrival);
    assign rd_bur_ext = fcfs_pkg::TIME_W'(rd_data_reg.burst);
    assign done_time  = start_reg + rd_bur_ext;
    assign wait_full  = start_reg - rd_arr_ext;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        clock_next   = clock_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        new_next     = new_reg;
        start_next   = start_reg;
        out_next     = out_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg + fcfs_pkg::ADDR_W'(1);
        wr_data      = new_reg;
        rd_addr      = pos_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // prefetch the top entry for the insertion step
                rd_addr = count_reg[fcfs_pkg::ADDR_W-1:0] - fcfs_pkg::ADDR_W'(1);
                if (rec_accept)
                begin
                    new_next.proc_id = records.data.proc_id;
                    new_next.arrival = records.data.arrival_time;
                    new_next.burst   = records.data.burst_time;
                    last_next        = records.data.last_item;
                    if (count_reg < fcfs_pkg::CNT_W'(fcfs_pkg::MAX_PROCS))
                    begin
                        if (count_reg == '0)
                        begin
                            state_next = S_INSERT;
                        end
                        else
                        begin
                            pos_next   = count_reg[fcfs_pkg::ADDR_W-1:0]
                                         - fcfs_pkg::ADDR_W'(1);
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                        if (records.data.last_item)
                        begin
                            pos_next   = '0;
                            clock_next = '0;
                            state_next = S_RUN_RD;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                wr_en = 1'b1;
                if (rd_data_reg.arrival > new_reg.arrival)
                begin
                    // later entry moves up one slot
                    wr_data = rd_data_reg;
                    rd_addr = pos_reg - fcfs_pkg::ADDR_W'(1);
                    if (pos_reg == '0)
                    begin
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        pos_next = pos_reg - fcfs_pkg::ADDR_W'(1);
                    end
                end
                else
                begin
                    // slot found just above this entry
                    wr_data    = new_reg;
                    count_next = count_reg + fcfs_pkg::CNT_W'(1);
                    if (last_reg)
                    begin
                        pos_next   = '0;
                        clock_next = '0;
                        state_next = S_RUN_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_INSERT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = new_reg;
                count_next = count_reg + fcfs_pkg::CNT_W'(1);
                if (last_reg)
                begin
                    pos_next   = '0;
                    clock_next = '0;
                    state_next = S_RUN_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_RUN_RD:
            begin
                rd_addr    = pos_reg;
                state_next = S_RUN_MAX;
            end

            S_RUN_MAX:
            begin
                // idle clock jumps forward to the arrival
                start_next = (clock_reg < rd_arr_ext) ? rd_arr_ext : clock_reg;
                out_next.out_proc_id = rd_data_reg.proc_id;
                out_next.out_arrival = rd_data_reg.arrival;
                out_next.out_burst   = rd_data_reg.burst;
                out_next.overflow    = dropped_reg;
                out_next.last_result =
                    ((fcfs_pkg::CNT_W'(pos_reg) + fcfs_pkg::CNT_W'(1)) == count_reg);
                state_next = S_RUN_ADD;
            end

            S_RUN_ADD:
            begin
                out_next.completion_time = done_time;
                out_next.waiting_time    = wait_full[fcfs_pkg::WAIT_W-1:0];
                clock_next               = done_time;
                state_next               = S_RUN_TURN;
            end

            S_RUN_TURN:
            begin
                out_next.turnaround_time = out_reg.completion_time
                    - fcfs_pkg::TIME_W'(out_reg.out_arrival);
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (results.ready)
                begin
                    if (out_reg.last_result)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        clock_next   = '0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + fcfs_pkg::ADDR_W'(1);
                        state_next = S_RUN_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            clock_reg   <= '0;
            pos_reg     <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            clock_reg   <= clock_next;
            pos_reg     <= pos_next;
            last_reg    <= last_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        new_reg   <= new_next;
        start_reg <= start_next;
        out_reg   <= out_next;
    end

    // Record memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

>>> design/fcfs_checker.sv
// Port-level assertions for the FCFS scheduling table, bound to the top level.
module fcfs_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           rec_ready,
    input logic           res_valid,
    input logic           res_ready,
    input fcfs_pkg::res_t res_data
);

    // A held result keeps its payload until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
        else $error("result changed while stalled");

    // Loading and result delivery never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !rec_ready)
        else $error("record port ready while a result is pending");

    // Turnaround is waiting plus burst
    a_turn_sum: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.turnaround_time ==
            (fcfs_pkg::TIME_W'(res_data.waiting_time)
             + fcfs_pkg::TIME_W'(res_data.out_burst))))
        else $error("turnaround does not equal waiting plus burst");

    // Completion is arrival plus turnaround
    a_done_sum: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.completion_time ==
            (res_data.turnaround_time + fcfs_pkg::TIME_W'(res_data.out_arrival))))
        else $error("completion does not equal arrival plus turnaround");

endmodule

bind fcfs_schedule_metrics fcfs_checker u_fcfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_ready (records.ready),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_data  (results.data)
);

>>> test/fcfs_schedule_metrics_tb.sv
// Self-checking testbench for the FCFS scheduling table: record sets in, schedule metrics out.
`timescale 1ns / 100ps

module fcfs_schedule_metrics_tb;

    // Run bounds
    localparam int CYCLE_LIMIT  = 300000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 2 * fcfs_pkg::MAX_PROCS + 20;
    localparam int RAND_ITEMS   = 90;

    // Receiver stall patterns
    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_e;

    logic clk = 1'b0;
    logic rst_n;

    fcfs_rec_if rec_ch ();
    fcfs_res_if res_ch ();

    fcfs_schedule_metrics dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .records (rec_ch),
        .results (res_ch)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Records waiting to be sent, the set being loaded, and the metrics still owed
    fcfs_pkg::rec_t   rec_pend_q[$];
    fcfs_pkg::entry_t set_recs[$];
    logic             set_dropped = 1'b0;
    fcfs_pkg::res_t   sched_exp_q[$];

    int err_cnt = 0;
    int cyc_cnt = 0;

    // One line per mismatch; printing is capped, counting is not
    task automatic log_mismatch(input string msg);
        if (err_cnt < 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input logic [15:0] id);
        if (got !== want)
            log_mismatch($sformatf("id %0h %s got %0h want %0h", id, name, got, want));
    endtask

    // Stable sort of the loaded set by arrival, then the FCFS timeline
    function automatic void predict_schedule();
        fcfs_pkg::entry_t            ord[$];
        fcfs_pkg::entry_t            tmp;
        int                          j;
        logic [fcfs_pkg::TIME_W-1:0] now;
        logic [fcfs_pkg::TIME_W-1:0] turn;
        fcfs_pkg::res_t              r;

        ord = set_recs;
        for (int i = 1; i < ord.size(); i++)
        begin
            tmp = ord[i];
            j   = i;
            while (j > 0 && ord[j-1].arrival > tmp.arrival)
            begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = tmp;
        end

        now = '0;
        foreach (ord[k])
        begin
            // idle CPU jumps forward to the arrival
            if (now < fcfs_pkg::TIME_W'(ord[k].arrival))
                now = fcfs_pkg::TIME_W'(ord[k].arrival);
            now  = now + fcfs_pkg::TIME_W'(ord[k].burst);
            turn = now - fcfs_pkg::TIME_W'(ord[k].arrival);
            r.out_proc_id     = ord[k].proc_id;
            r.out_arrival     = ord[k].arrival;
            r.out_burst       = ord[k].burst;
            r.completion_time = now;
            r.turnaround_time = turn;
            r.waiting_time    = fcfs_pkg::WAIT_W'(turn - fcfs_pkg::TIME_W'(ord[k].burst));
            r.overflow        = set_dropped;
            r.last_result     = (k == ord.size() - 1);
            sched_exp_q.push_back(r);
        end
    endfunction

    // Store an accepted record; past capacity it is dropped and flags the set
    function automatic void accept_record(input fcfs_pkg::rec_t r);
        fcfs_pkg::entry_t e;
        e.proc_id = r.proc_id;
        e.arrival = r.arrival_time;
        e.burst   = r.burst_time;
        if (set_recs.size() < fcfs_pkg::MAX_PROCS)
            set_recs.push_back(e);
        else
            set_dropped = 1'b1;
        if (r.last_item)
        begin
            predict_schedule();
            set_recs.delete();
            set_dropped = 1'b0;
        end
    endfunction

    function automatic fcfs_pkg::rec_t make_rec(input int amode, input int bmode,
                                                input logic [15:0] abase, input logic last);
        fcfs_pkg::rec_t r;
        r.proc_id = 16'($urandom_range(0, 65535));
        case (amode)
            0:       r.arrival_time = 16'($urandom_range(0, 65535));
            1:       r.arrival_time = abase + 16'($urandom_range(0, 7));
            default: r.arrival_time = abase;
        endcase
        case (bmode)
            0:       r.burst_time = 16'($urandom_range(0, 65535));
            1:       r.burst_time = 16'($urandom_range(0, 3));
            default: r.burst_time = 16'($urandom_range(0, 255));
        endcase
        r.last_item = last;
        return r;
    endfunction

    function automatic void add_rec(input logic [15:0] id, input logic [15:0] arr,
                                    input logic [15:0] bur, input logic last);
        fcfs_pkg::rec_t r;
        r.proc_id      = id;
        r.arrival_time = arr;
        r.burst_time   = bur;
        r.last_item    = last;
        rec_pend_q.push_back(r);
    endfunction

    // Record driver: random bursts and gaps, holds each transaction until taken
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin : rec_driver
        fcfs_pkg::rec_t nxt;
        logic           nxt_v;
        if (!rst_n)
        begin
            rec_ch.valid <= 1'b0;
            rec_ch.data  <= '0;
            burst_left   <= 0;
            gap_left     <= 0;
        end
        else
        begin
            nxt_v = rec_ch.valid;
            nxt   = rec_ch.data;
            if (rec_ch.valid && rec_ch.ready)
            begin
                accept_record(rec_ch.data);
                nxt_v = 1'b0;
            end
            if (!nxt_v)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (rec_pend_q.size() > 0)
                begin
                    nxt   = rec_pend_q.pop_front();
                    nxt_v = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
            rec_ch.valid <= nxt_v;
            rec_ch.data  <= nxt;
        end
    end

    // Result sink: changing stall patterns plus one long hold-off mid-set
    rx_mode_e rx_mode;
    int       mode_left;
    int       hold_left;
    int       rx_phase;
    int       rx_taken;
    logic     long_done;

    always @(posedge clk or negedge rst_n)
    begin : res_sink
        logic nxt_r;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            rx_mode      <= RX_OPEN;
            mode_left    <= 0;
            hold_left    <= 0;
            rx_phase     <= 0;
            rx_taken     <= 0;
            long_done    <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
                rx_taken <= rx_taken + 1;
            rx_phase <= rx_phase + 1;
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                nxt_r = 1'b0;
            end
            else if (!long_done && rx_taken >= 10 && res_ch.valid)
            begin
                // block backs up and must refuse the next set meanwhile
                hold_left <= LONG_HOLD;
                long_done <= 1'b1;
                nxt_r = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   <= rx_mode_e'($urandom_range(0, 2));
                    mode_left <= $urandom_range(20, 80);
                end
                else
                    mode_left <= mode_left - 1;
                case (rx_mode)
                    RX_OPEN:   nxt_r = 1'b1;
                    RX_RANDOM: nxt_r = ($urandom_range(0, 99) < 60);
                    default:   nxt_r = (rx_phase % 3 == 0);
                endcase
            end
            res_ch.ready <= nxt_r;
        end
    end

    // Result monitor: each transaction against the oldest expectation
    always @(posedge clk)
    begin : res_monitor
        fcfs_pkg::res_t got;
        fcfs_pkg::res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.data;
            if (sched_exp_q.size() == 0)
                log_mismatch($sformatf("result id %0h with none expected", got.out_proc_id));
            else
            begin
                want = sched_exp_q.pop_front();
                check_field("proc_id", got.out_proc_id, want.out_proc_id, want.out_proc_id);
                check_field("arrival", got.out_arrival, want.out_arrival, want.out_proc_id);
                check_field("burst", got.out_burst, want.out_burst, want.out_proc_id);
                check_field("completion", got.completion_time, want.completion_time,
                            want.out_proc_id);
                check_field("turnaround", got.turnaround_time, want.turnaround_time,
                            want.out_proc_id);
                check_field("waiting", got.waiting_time, want.waiting_time, want.out_proc_id);
                check_field("overflow", got.overflow, want.overflow, want.out_proc_id);
                check_field("last_result", got.last_result, want.last_result,
                            want.out_proc_id);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cyc_cnt++;
        if (cyc_cnt > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int          n_rand;
        int          set_len;
        int          amode;
        int          bmode;
        logic [15:0] abase;
        logic        big_done;

        rst_n = 1'b0;

        // single-record sets at both extremes
        add_rec(16'h0000, 16'h0000, 16'h0000, 1'b1);
        add_rec(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);

        // equal arrivals keep load order; zero and full bursts
        add_rec(16'd1, 16'd10, 16'd5, 1'b0);
        add_rec(16'd2, 16'd3, 16'd4, 1'b0);
        add_rec(16'd3, 16'd10, 16'd0, 1'b0);
        add_rec(16'd4, 16'd3, 16'd2, 1'b0);
        add_rec(16'd5, 16'd100, 16'd7, 1'b0);
        add_rec(16'd6, 16'd0, 16'hFFFF, 1'b0);
        add_rec(16'd7, 16'd10, 16'd1, 1'b1);

        // idle gaps in the timeline, clock jumps to arrival
        add_rec(16'd10, 16'd50, 16'd5, 1'b0);
        add_rec(16'd11, 16'd5, 16'd3, 1'b0);
        add_rec(16'd12, 16'd20, 16'd0, 1'b0);
        add_rec(16'd13, 16'd5, 16'd1, 1'b1);

        // reversed arrivals, max values, ties at zero
        add_rec(16'd20, 16'hFFFF, 16'hFFFF, 1'b0);
        add_rec(16'd21, 16'hFFFE, 16'd1, 1'b0);
        add_rec(16'd22, 16'd0, 16'd0, 1'b0);
        add_rec(16'd23, 16'd0, 16'hFFFF, 1'b1);

        // random sets, mostly small; one overruns capacity and drops its records past capacity
        n_rand   = 0;
        big_done = 1'b0;
        while (n_rand < RAND_ITEMS)
        begin
            if (!big_done && n_rand >= 20)
            begin
                set_len  = $urandom_range(fcfs_pkg::MAX_PROCS + 1, fcfs_pkg::MAX_PROCS + 4);
                big_done = 1'b1;
            end
            else
                set_len = $urandom_range(1, 8);
            amode = $urandom_range(0, 2);
            bmode = $urandom_range(0, 2);
            abase = 16'($urandom_range(0, 65535));
            for (int i = 0; i < set_len; i++)
                rec_pend_q.push_back(make_rec(amode, bmode, abase, i == set_len - 1));
            n_rand += set_len;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (rec_pend_q.size() > 0 || rec_ch.valid)
            @(posedge clk);
        while (sched_exp_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
